FILE: design/ipid_pkg.sv
// Shared widths, register codes and record types of the two-channel incremental PID.
`default_nettype none

package ipid_pkg;

  localparam int DATA_W           = 16;
  localparam int COEF_W           = 16;
  localparam int ERR_W            = DATA_W + 1;
  localparam int PROD_W           = COEF_W + 1 + ERR_W;
  localparam int SUM_W            = PROD_W + 2;
  localparam int COEF_FRAC_BITS   = 12;
  localparam int INC_W            = SUM_W - COEF_FRAC_BITS;
  localparam int ACC_SUM_W        = INC_W + 1;
  localparam int SHIFT_W          = 4;
  localparam int DB_W             = 8;
  localparam int CFG_IDX_W        = 3;
  localparam int DEFAULT_CHANNELS = 2;

  localparam logic [COEF_W-1:0]         RST_COEF_NOW   = 16'd451;
  localparam logic [COEF_W-1:0]         RST_COEF_PREV  = 16'd225;
  localparam logic [COEF_W-1:0]         RST_COEF_PREV2 = 16'd0;
  localparam logic [SHIFT_W-1:0]        RST_SHIFT      = 4'd0;
  localparam logic [DB_W-1:0]           RST_DEAD_BAND  = 8'd8;
  localparam logic signed [DATA_W-1:0]  RST_OUT_HIGH   = 16'sd1000;
  localparam logic signed [DATA_W-1:0]  RST_OUT_LOW    = -16'sd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_NOW,
    CFG_COEF_PREV,
    CFG_COEF_PREV2,
    CFG_RESULT_SHIFT,
    CFG_DEAD_BAND,
    CFG_OUT_HIGH,
    CFG_OUT_LOW
  } cfg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0]        coef_now;
    logic [COEF_W-1:0]        coef_prev;
    logic [COEF_W-1:0]        coef_prev2;
    logic [SHIFT_W-1:0]       result_shift;
    logic [DB_W-1:0]          dead_band;
    logic signed [DATA_W-1:0] out_high;
    logic signed [DATA_W-1:0] out_low;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err_last;
    logic signed [ERR_W-1:0]  err_before_last;
    logic signed [DATA_W-1:0] acc;
  } state_t;

endpackage

`default_nettype wire

FILE: design/ipid_state_ram.sv
// Per-channel controller state memory: one write port, one registered read port.
`default_nettype none

module ipid_state_ram
  import ipid_pkg::*;
#(
  parameter int CHANNELS = DEFAULT_CHANNELS,
  parameter int CH_W     = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            rd_en,
  input  wire logic [CH_W-1:0] rd_addr,
  output state_t               rd_data,
  input  wire logic            wr_en,
  input  wire logic [CH_W-1:0] wr_addr,
  input  wire state_t          wr_data
);

  state_t                mem [CHANNELS];
  logic [CHANNELS-1:0]   written;
  state_t                rd_word;
  logic                  rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // Entries never written read as the zero reset state.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_written ? rd_word : '0;

endmodule

`default_nettype wire

FILE: design/ipid_update_pipe.sv
// Update pipeline: products, increment and accumulate, shift and clamp, result register.
`default_nettype none

module ipid_update_pipe
  import ipid_pkg::*;
#(
  parameter int CH_W = 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    advance,
  input  wire logic                    in_vld,
  input  wire logic [CH_W-1:0]         in_ch,
  input  wire logic signed [ERR_W-1:0] in_err,
  input  wire logic                    in_dbf,
  input  wire cfg_t                    cfg,
  input  wire state_t                  rd_state,
  output logic                         hazard,
  output logic                         wr_en,
  output logic [CH_W-1:0]              wr_addr,
  output state_t                       wr_data,
  output logic                         out_vld,
  output logic [DATA_W-1:0]            out_drive,
  output logic                         out_dbf,
  output logic                         out_clamped
);

  logic                     s1_vld, s2_vld, s3_vld;
  logic [CH_W-1:0]          s1_ch, s2_ch, s3_ch;
  logic signed [ERR_W-1:0]  s1_err, s2_err, s3_err;
  logic                     s1_dbf, s2_dbf, s3_dbf;
  logic signed [ERR_W-1:0]  s2_err_last, s3_err_last;
  logic signed [DATA_W-1:0] s2_acc, s3_acc;
  logic signed [PROD_W-1:0] s2_p0, s2_p1, s2_p2;
  logic signed [ACC_SUM_W-1:0] s3_sum;

  logic signed [PROD_W-1:0]    p0, p1, p2;
  logic signed [SUM_W-1:0]     sum, sum_adj;
  logic signed [INC_W-1:0]     inc;
  logic signed [ACC_SUM_W-1:0] acc_sum;
  logic signed [ACC_SUM_W-1:0] shifted, hi_x, lo_x;
  logic [DATA_W-1:0]           res;
  logic                        clp;

  // Stage 1: state word arrives from memory, form the three products.
  always_comb begin
    p0 = $signed({1'b0, cfg.coef_now})   * s1_err;
    p1 = $signed({1'b0, cfg.coef_prev})  * rd_state.err_last;
    p2 = $signed({1'b0, cfg.coef_prev2}) * rd_state.err_before_last;
  end

  // Stage 2: combine, drop the fraction toward zero, add the accumulator.
  always_comb begin
    sum = $signed({{(SUM_W-PROD_W){s2_p0[PROD_W-1]}}, s2_p0})
        - $signed({{(SUM_W-PROD_W){s2_p1[PROD_W-1]}}, s2_p1})
        + $signed({{(SUM_W-PROD_W){s2_p2[PROD_W-1]}}, s2_p2});
    sum_adj = sum[SUM_W-1] ? sum + SUM_W'((1 << COEF_FRAC_BITS) - 1) : sum;
    inc     = sum_adj[SUM_W-1:COEF_FRAC_BITS];
    acc_sum = $signed({inc[INC_W-1], inc})
            + $signed({{(ACC_SUM_W-DATA_W){s2_acc[DATA_W-1]}}, s2_acc});
  end

  // Stage 3: floor shift and clamp; upper limit is tested first.
  always_comb begin
    shifted = s3_sum >>> cfg.result_shift;
    hi_x    = $signed({{(ACC_SUM_W-DATA_W){cfg.out_high[DATA_W-1]}}, cfg.out_high});
    lo_x    = $signed({{(ACC_SUM_W-DATA_W){cfg.out_low[DATA_W-1]}}, cfg.out_low});
    if (shifted >= hi_x) begin
      res = cfg.out_high;
      clp = 1'b1;
    end else if (shifted <= lo_x) begin
      res = cfg.out_low;
      clp = 1'b1;
    end else begin
      res = shifted[DATA_W-1:0];
      clp = 1'b0;
    end
  end

  assign hazard = (s1_vld && (s1_ch == in_ch))
               || (s2_vld && (s2_ch == in_ch))
               || (s3_vld && (s3_ch == in_ch));

  assign wr_en                   = advance && s3_vld && !s3_dbf;
  assign wr_addr                 = s3_ch;
  assign wr_data.err_last        = s3_err;
  assign wr_data.err_before_last = s3_err_last;
  assign wr_data.acc             = res;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ch       <= in_ch;
      s1_err      <= in_err;
      s1_dbf      <= in_dbf;
      s2_ch       <= s1_ch;
      s2_err      <= s1_err;
      s2_dbf      <= s1_dbf;
      s2_err_last <= rd_state.err_last;
      s2_acc      <= rd_state.acc;
      s2_p0       <= p0;
      s2_p1       <= p1;
      s2_p2       <= p2;
      s3_ch       <= s2_ch;
      s3_err      <= s2_err;
      s3_dbf      <= s2_dbf;
      s3_err_last <= s2_err_last;
      s3_acc      <= s2_acc;
      s3_sum      <= acc_sum;
      out_dbf     <= s3_dbf;
      if (s3_dbf) begin
        out_drive   <= s3_acc;
        out_clamped <= 1'b0;
      end else begin
        out_drive   <= res;
        out_clamped <= clp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      s3_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (advance) begin
      s1_vld  <= in_vld;
      s2_vld  <= s1_vld;
      s3_vld  <= s2_vld;
      out_vld <= s3_vld;
    end
  end

endmodule

`default_nettype wire

FILE: design/incremental_pid_two_channel_unit.sv
// Top level of the two-channel incremental PID: stream ports, registers, state interlock.
`default_nettype none

// Velocity-form PID over CHANNELS controller channels, state kept in a small
// memory read at accept and written back after the clamp, except for a
// deadband result. A new transaction is taken every cycle while the output
// does not stall and its channel has no transaction in flight; a transaction
// on the same channel as one in flight waits until that one has left the
// shift-and-clamp stage, so one channel cannot take a transaction before its
// last one is through, while two channels interleave. The read-modify-write
// of the state memory through the four pipeline stages (products, accumulate,
// shift and clamp, output register) sets these limits. The output register
// stalls the whole pipeline while a result waits. The state memory needs no
// clearing pass: per-entry valid bits make unwritten entries read as zero.
module incremental_pid_two_channel_unit
  import ipid_pkg::*;
#(
  parameter int CHANNELS = DEFAULT_CHANNELS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [31:0]          s_tdata,   // target [15:0], measured [31:16]
  input  wire logic [0:0]           s_tuser,   // channel [0]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [DATA_W-1:0]         m_tdata,   // drive [15:0]
  output logic [1:0]                m_tuser,   // in_deadband [0], clamped [1]
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_t                    cfg;
  logic                    advance;
  logic                    hazard;
  logic                    in_vld;
  logic [CH_W-1:0]         in_ch;
  logic signed [ERR_W-1:0] in_err;
  logic [ERR_W-1:0]        in_mag;
  logic                    in_dbf;
  state_t                  rd_state;
  logic                    wr_en;
  logic [CH_W-1:0]         wr_addr;
  state_t                  wr_data;
  logic                    out_dbf;
  logic                    out_clamped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_now     <= RST_COEF_NOW;
      cfg.coef_prev    <= RST_COEF_PREV;
      cfg.coef_prev2   <= RST_COEF_PREV2;
      cfg.result_shift <= RST_SHIFT;
      cfg.dead_band    <= RST_DEAD_BAND;
      cfg.out_high     <= RST_OUT_HIGH;
      cfg.out_low      <= RST_OUT_LOW;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COEF_NOW:     cfg.coef_now     <= cfg_data;
        CFG_COEF_PREV:    cfg.coef_prev    <= cfg_data;
        CFG_COEF_PREV2:   cfg.coef_prev2   <= cfg_data;
        CFG_RESULT_SHIFT: cfg.result_shift <= cfg_data[SHIFT_W-1:0];
        CFG_DEAD_BAND:    cfg.dead_band    <= cfg_data[DB_W-1:0];
        CFG_OUT_HIGH:     cfg.out_high     <= cfg_data;
        CFG_OUT_LOW:      cfg.out_low      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate a channel number beyond the configured count.
  assign in_ch = (32'(s_tuser[0]) >= 32'(CHANNELS)) ? CH_W'(CHANNELS - 1)
                                                     : CH_W'(s_tuser[0]);

  always_comb begin
    in_err = $signed({s_tdata[15], s_tdata[15:0]})
           - $signed({s_tdata[31], s_tdata[31:16]});
    in_mag = in_err[ERR_W-1] ? ERR_W'(-in_err) : in_err;
    in_dbf = in_mag <= {{(ERR_W-DB_W){1'b0}}, cfg.dead_band};
  end

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance && !hazard;
  assign in_vld   = s_tvalid && s_tready;

  ipid_state_ram #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (advance),
    .rd_addr (in_ch),
    .rd_data (rd_state),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ipid_update_pipe #(
    .CH_W (CH_W)
  ) u_pipe (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .in_vld      (in_vld),
    .in_ch       (in_ch),
    .in_err      (in_err),
    .in_dbf      (in_dbf),
    .cfg         (cfg),
    .rd_state    (rd_state),
    .hazard      (hazard),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_vld     (m_tvalid),
    .out_drive   (m_tdata),
    .out_dbf     (out_dbf),
    .out_clamped (out_clamped)
  );

  assign m_tuser = {out_clamped, out_dbf};

  // A deadband result never reports a clamp.
  a_dbf_no_clamp : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1])
    else $error("deadband result flagged as clamped");

  // A clamped result sits on one of the limits.
  a_clamp_on_limit : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] && m_tuser[1] |->
      ($signed(m_tdata) == cfg.out_high) || ($signed(m_tdata) == cfg.out_low))
    else $error("clamped result off the limits");

  // An unclamped update lies strictly inside ordered limits.
  a_inside_limits : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] && !m_tuser[1] && (cfg.out_low <= cfg.out_high) |->
      ($signed(m_tdata) > cfg.out_low) && ($signed(m_tdata) < cfg.out_high))
    else $error("unclamped result outside the limits");

endmodule

`default_nettype wire
